@@ rtl/core/tcp_pkg.sv @@
// Shared constants, tables and types for the tape character to punch code unit.
package tcp_pkg;

    localparam int LINE_COUNT_BITS = 16;
    localparam int CHAR_BITS       = 16;
    localparam int CODE_BITS       = 5;
    localparam int TAB_DEPTH       = 32;

    typedef logic [CHAR_BITS-1:0]       t_char;
    typedef logic [CODE_BITS-1:0]       t_code;
    typedef logic [LINE_COUNT_BITS-1:0] t_line;

    // Command codes carried on the input channel.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_CHAR = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    // Status codes carried on the output channel.
    localparam logic [1:0] ST_CODE    = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_END     = 2'd2;

    localparam t_char CH_LF     = 16'h000A;
    localparam t_char CH_OPEN   = 16'h005B;
    localparam t_char CH_CLOSE  = 16'h005D;

    localparam t_char LETTER_TAB [TAB_DEPTH] = '{
        16'h0050, 16'h0051, 16'h0057, 16'h0045, 16'h0052, 16'h0054, 16'h0059, 16'h0055,
        16'h0049, 16'h004F, 16'h004A, 16'h03C0, 16'h0053, 16'h005A, 16'h004B, 16'h002A,
        16'h002E, 16'h0046, 16'h03B8, 16'h0044, 16'h03A6, 16'h0048, 16'h004E, 16'h004D,
        16'h0394, 16'h004C, 16'h0058, 16'h0047, 16'h0041, 16'h0042, 16'h0043, 16'h0056
    };

    localparam t_char FIGURE_TAB [TAB_DEPTH] = '{
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h004A, 16'h0023, 16'h0022, 16'h00A7, 16'h0028, 16'h002A,
        16'h002E, 16'h0046, 16'h0040, 16'h0044, 16'h0021, 16'h002B, 16'h002D, 16'h0027,
        16'h0026, 16'h0025, 16'h0058, 16'h0047, 16'h003A, 16'h003F, 16'h0028, 16'h0029
    };

    // Classification of one character, passed from the lookup to the top level.
    typedef struct packed {
        logic  blank;
        logic  hit;
        t_code idx;
    } t_lookup;

endpackage

@@ rtl/core/tcp_ifs.sv @@
// Valid/ready channel interfaces for input, output and configuration.
interface tcp_in_if;
    logic           valid;
    logic           ready;
    logic [1:0]     command;
    tcp_pkg::t_char char_code;
    modport source (output valid, output command, output char_code, input ready);
    modport sink   (input valid, input command, input char_code, output ready);
endinterface

interface tcp_out_if;
    logic           valid;
    logic           ready;
    logic [1:0]     status;
    tcp_pkg::t_code punch_code;
    tcp_pkg::t_char line_number;
    tcp_pkg::t_char bad_char;
    modport source (output valid, output status, output punch_code, output line_number,
                    output bad_char, input ready);
    modport sink   (input valid, input status, input punch_code, input line_number,
                    input bad_char, output ready);
endinterface

interface tcp_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/tcp_lookup.sv @@
// Whitespace detection and letter/figure table search for one character.
module tcp_lookup (
    input  tcp_pkg::t_char   i_char,
    input  logic             i_fold_case,
    output tcp_pkg::t_lookup o_result
);

    tcp_pkg::t_char                 folded;
    logic [tcp_pkg::TAB_DEPTH-1:0]  let_match;
    logic [tcp_pkg::TAB_DEPTH-1:0]  fig_match;
    tcp_pkg::t_code                 let_idx;
    tcp_pkg::t_code                 fig_idx;
    logic                           blank;

    always_comb begin
        blank = 1'b0;
        if (i_char >= 16'h0009 && i_char <= 16'h000D) blank = 1'b1;
        if (i_char == 16'h0020 || i_char == 16'h0085 || i_char == 16'h00A0 ||
            i_char == 16'h1680) blank = 1'b1;
        if (i_char >= 16'h2000 && i_char <= 16'h200A) blank = 1'b1;
        if (i_char == 16'h2028 || i_char == 16'h2029 || i_char == 16'h202F ||
            i_char == 16'h205F || i_char == 16'h3000) blank = 1'b1;
    end

    // Every letter table entry is its own fold, so only the input needs folding.
    always_comb begin
        folded = i_char;
        if (i_fold_case) begin
            if (i_char >= 16'h0061 && i_char <= 16'h007A) folded = i_char - 16'h0020;
            else if (i_char == 16'h03A0) folded = 16'h03C0;
            else if (i_char == 16'h0398) folded = 16'h03B8;
            else if (i_char == 16'h03C6) folded = 16'h03A6;
            else if (i_char == 16'h03B4) folded = 16'h0394;
        end
    end

    always_comb begin
        for (int i = 0; i < tcp_pkg::TAB_DEPTH; i++) begin
            let_match[i] = (tcp_pkg::LETTER_TAB[i] == folded);
            fig_match[i] = (tcp_pkg::FIGURE_TAB[i] == i_char);
        end
    end

    // Scan from the top down so that the lowest matching position wins.
    always_comb begin
        let_idx = '0;
        fig_idx = '0;
        for (int i = tcp_pkg::TAB_DEPTH - 1; i >= 0; i--) begin
            if (let_match[i]) let_idx = tcp_pkg::CODE_BITS'(i);
            if (fig_match[i]) fig_idx = tcp_pkg::CODE_BITS'(i);
        end
    end

    assign o_result.blank = blank;
    assign o_result.hit   = (|let_match) | (|fig_match);
    assign o_result.idx   = (|let_match) ? let_idx : fig_idx;

endmodule

@@ rtl/core/tape_char_to_punch_code_unit.sv @@
// Top level: input register, character classification and registered result.
// Path: an accepted input passes the input register, then the result register.
// Throughput: one item per cycle; the single compute stage between the input
// register and the result register sets that figure, and it stalls only while a
// finished result waits on the output channel.
// Reset: synchronous, active low; clears fold_case, comment flag and valid bits and
// sets the line counter to one.
module tape_char_to_punch_code_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcp_in_if.sink    i_in,
    tcp_cfg_if.sink   i_cfg,
    tcp_out_if.source o_out
);

    logic             r_fold_case;
    logic             r_in_comment, n_in_comment;
    tcp_pkg::t_line   r_line, n_line;

    logic             r_s1_valid;
    logic [1:0]       r_s1_cmd;
    tcp_pkg::t_char   r_s1_char;

    logic             r_out_valid;
    logic [1:0]       r_out_status, n_status;
    tcp_pkg::t_code   r_out_code, n_code;
    tcp_pkg::t_char   r_out_line;
    tcp_pkg::t_char   r_out_bad, n_bad;

    logic             s1_adv;
    logic             produce;
    logic             at_top;
    tcp_pkg::t_char   line_sat;
    tcp_pkg::t_lookup look;

    tcp_lookup u_lookup (
        .i_char      (r_s1_char),
        .i_fold_case (r_fold_case),
        .o_result    (look)
    );

    assign s1_adv      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_adv;
    assign i_cfg.ready = 1'b1;
    assign at_top      = (r_line == '1);

    generate
        if (tcp_pkg::LINE_COUNT_BITS > tcp_pkg::CHAR_BITS) begin : g_sat
            assign line_sat = (|r_line[tcp_pkg::LINE_COUNT_BITS-1:tcp_pkg::CHAR_BITS])
                              ? '1 : r_line[tcp_pkg::CHAR_BITS-1:0];
        end else begin : g_ext
            assign line_sat = tcp_pkg::CHAR_BITS'(r_line);
        end
    endgenerate

    always_comb begin
        n_in_comment = r_in_comment;
        n_line       = r_line;
        produce      = 1'b0;
        n_status     = tcp_pkg::ST_CODE;
        n_code       = '0;
        n_bad        = '0;
        unique case (r_s1_cmd)
            tcp_pkg::CMD_LOAD: begin
                n_in_comment = 1'b0;
                n_line       = tcp_pkg::LINE_COUNT_BITS'(1);
            end
            tcp_pkg::CMD_END: begin
                produce  = 1'b1;
                n_status = tcp_pkg::ST_END;
            end
            tcp_pkg::CMD_CHAR: begin
                if (r_s1_char == tcp_pkg::CH_LF) begin
                    if (!at_top) n_line = r_line + 1'b1;
                end else if (r_in_comment) begin
                    if (r_s1_char == tcp_pkg::CH_CLOSE) n_in_comment = 1'b0;
                end else if (look.blank) begin
                    n_in_comment = r_in_comment;
                end else if (r_s1_char == tcp_pkg::CH_OPEN) begin
                    n_in_comment = 1'b1;
                end else if (look.hit) begin
                    produce = 1'b1;
                    n_code  = look.idx;
                end else begin
                    produce  = 1'b1;
                    n_status = tcp_pkg::ST_ILLEGAL;
                    n_bad    = r_s1_char;
                end
            end
            default: begin
                produce = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_case  <= 1'b0;
            r_in_comment <= 1'b0;
            r_line       <= tcp_pkg::LINE_COUNT_BITS'(1);
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) r_fold_case <= i_cfg.data;
            if (i_in.ready) r_s1_valid <= i_in.valid;
            if (s1_adv) begin
                r_in_comment <= n_in_comment;
                r_line       <= n_line;
            end
            if (s1_adv && produce) r_out_valid <= 1'b1;
            else if (o_out.ready)  r_out_valid <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_cmd  <= i_in.command;
            r_s1_char <= i_in.char_code;
        end
        if (s1_adv && produce) begin
            r_out_status <= n_status;
            r_out_code   <= n_code;
            r_out_line   <= line_sat;
            r_out_bad    <= n_bad;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.punch_code  = r_out_code;
    assign o_out.line_number = r_out_line;
    assign o_out.bad_char    = r_out_bad;

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line counter reached zero");

    a_load_resets_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_cmd == tcp_pkg::CMD_LOAD |=> r_line == tcp_pkg::LINE_COUNT_BITS'(1)
        && !r_in_comment)
        else $error("load command did not restart the tape state");

    a_fields_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.status == tcp_pkg::ST_CODE && o_out.bad_char == '0) ||
                         (o_out.status != tcp_pkg::ST_CODE && o_out.punch_code == '0)))
        else $error("result fields inconsistent with status");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_s1_valid && r_out_valid && !o_out.ready)
        else $error("input stalled without a blocked result");

endmodule
